### design/tsrs_pkg.sv
// Shared types, constants and helpers for the tagged status record store.
// Used by tsrs_front, tsrs_engine and tagged_status_record_store_top.
package tsrs_pkg;

  // Store geometry
  localparam int BUF_BYTES        = 256;
  localparam int MAX_STATUS_WORDS = 2;
  localparam int ADDR_W           = $clog2(BUF_BYTES);
  localparam int FILL_W           = ADDR_W + 1;   // holds 0..BUF_BYTES
  localparam int OFF_W            = ADDR_W + 2;   // walk offsets incl. overrun marker
  localparam int HDR_BYTES        = 16;

  localparam logic [31:0]      REC_SIG = 32'h3153_4349;
  // offset past any fill level: ends the next walk step as not found
  localparam logic [OFF_W-1:0] SAT_OFF = OFF_W'(BUF_BYTES + 1);

  // Stream widths
  localparam int IN_W  = 136;
  localparam int OUT_W = 72;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_NOT_FOUND = 3'd1,
    RC_BAD_SIG   = 3'd2,
    RC_TRUNC     = 3'd3,
    RC_SMALL     = 3'd4,
    RC_BAD_PARAM = 3'd5
  } rc_t;

  typedef enum logic [1:0] {
    K_LOOKUP = 2'd0,
    K_UPDATE = 2'd1,
    K_DELETE = 2'd2,
    K_BAD    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic [1:0]  sw;
    logic [31:0] w0;
    logic [31:0] w1;
  } cmd_t;

  typedef struct packed {
    rc_t         code;
    logic [1:0]  len;
    logic [31:0] w0;
    logic [31:0] w1;
  } res_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              busy;
  } stat_t;

  // One byte of a new record image: header, data words, then the end word.
  function automatic logic [7:0] rec_byte(input logic [4:0]  idx,
                                          input logic [1:0]  sw,
                                          input logic [63:0] key,
                                          input logic [31:0] w0,
                                          input logic [31:0] w1);
    logic [31:0] w;
    unique case (idx[4:2])
      3'd0:    w = REC_SIG;
      3'd1:    w = {28'd0, sw, 2'b00};
      3'd2:    w = key[31:0];
      3'd3:    w = key[63:32];
      3'd4:    w = w0;
      3'd5:    w = (sw == 2'd2) ? w1 : 32'd0;
      default: w = 32'd0;
    endcase
    return w[8*idx[1:0] +: 8];
  endfunction

endpackage

### design/tsrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/tsrs_front.sv
// Front end: takes input transfers, classifies the operation and queues it.
// Depends on tsrs_pkg.
module tsrs_front import tsrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            q_valid,
  output cmd_t            q_cmd,
  input  logic            q_pop
);

  logic [1:0]  op;
  logic [1:0]  sw;
  cmd_t        cmd;
  logic        push;

  cmd_t        q_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign op = in_data[1:0];
  assign sw = in_data[67:66];

  // classify: parameter checks are settled here
  always_comb begin
    cmd.key = in_data[65:2];
    cmd.sw  = sw;
    cmd.w0  = in_data[99:68];
    cmd.w1  = in_data[131:100];
    priority if (op == OP_LOOKUP) begin
      cmd.kind = (sw > 2'(MAX_STATUS_WORDS)) ? K_BAD : K_LOOKUP;
    end else if (op == OP_UPDATE) begin
      cmd.kind = (sw == 2'd0 || sw > 2'(MAX_STATUS_WORDS)) ? K_BAD : K_UPDATE;
    end else if (op == OP_DELETE) begin
      cmd.kind = K_DELETE;
    end else begin
      cmd.kind = K_BAD;
    end
  end

  // two-entry command queue
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

### design/tsrs_engine.sv
// Back end: sequencer that walks, edits and compacts the record store.
// Depends on tsrs_pkg and tsrs_ram (two banks: live store and scratch copy).
module tsrs_engine import tsrs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  cmd_t  q_cmd,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  res,
  output stat_t stat
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_RD    = 20'h00002,
    S_MOVE  = 20'h00004,
    S_UCHK  = 20'h00008,
    S_WALK  = 20'h00010,
    S_WSIG  = 20'h00020,
    S_WKLO  = 20'h00040,
    S_WKHI  = 20'h00080,
    S_WLEN  = 20'h00100,
    S_WFAIL = 20'h00200,
    S_FOUND = 20'h00400,
    S_LF0   = 20'h00800,
    S_LF1   = 20'h01000,
    S_RM    = 20'h02000,
    S_PLACE = 20'h04000,
    S_PDROP = 20'h08000,
    S_PFIT  = 20'h10000,
    S_PEV   = 20'h20000,
    S_PEVL  = 20'h40000,
    S_WRITE = 20'h80000
  } state_t;

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              cur_r, cur_nxt;
  logic              wb_r, wb_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] n_r, n_nxt;
  logic [FILL_W-1:0] na_r, na_nxt;
  logic [FILL_W-1:0] nn_r, nn_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [OFF_W-1:0]  rd_base_r, rd_base_nxt;
  logic [2:0]        rd_cnt_r, rd_cnt_nxt;
  logic              rd_oob_r, rd_oob_nxt;
  logic              hit_r, hit_nxt;
  rc_t               rc_r, rc_nxt;
  logic [FILL_W-1:0] mv_src_r, mv_src_nxt;
  logic [FILL_W-1:0] mv_dst_r, mv_dst_nxt;
  logic [FILL_W-1:0] mv_lim_r, mv_lim_nxt;
  logic              mv_copy_r, mv_copy_nxt;
  logic              pw_r, pw_nxt;
  logic [ADDR_W-1:0] pw_addr_r, pw_addr_nxt;
  logic [FILL_W-1:0] wr_base_r, wr_base_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic [4:0]        idx_end_r, idx_end_nxt;
  logic [31:0]       f0_r, f0_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  // finish and word-read requests from the state logic
  logic              fin, fin_commit_upd, fin_commit_del;
  rc_t               fin_code;
  logic [1:0]        fin_len;
  logic [31:0]       fin_w0, fin_w1;
  logic              rd_go;
  logic [OFF_W-1:0]  rd_at;
  state_t            rd_ret;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        rdata0, rdata1, rbyte;

  logic [OFF_W-1:0]  rd_addr, wr_addr, n_ext;
  logic [32:0]       walk_next, rm_end;
  logic [FILL_W:0]   need;
  logic [31:0]       len_want;

  tsrs_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_bank0 (
    .clk(clk), .we(ram_we && !wb_r), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata0)
  );

  tsrs_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_bank1 (
    .clk(clk), .we(ram_we && wb_r), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata1)
  );

  // the copy pass reads the live bank, all other reads use the work bank
  assign rbyte = (mv_copy_r ? cur_r : wb_r) ? rdata1 : rdata0;

  assign rd_addr   = rd_base_r + OFF_W'(rd_cnt_r);
  assign wr_addr   = {1'b0, wr_base_r} + OFF_W'(idx_r);
  assign n_ext     = {1'b0, n_r};
  assign walk_next = 33'(off_r) + 33'(HDR_BYTES) + {1'b0, word_r};
  assign rm_end    = 33'(off_r) + 33'(HDR_BYTES) + {1'b0, len_r};
  assign need      = {1'b0, na_r} + (FILL_W+1)'(HDR_BYTES + 4)
                     + (FILL_W+1)'({cmd_r.sw, 2'b00});
  assign len_want  = {28'd0, cmd_r.sw, 2'b00};

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    cmd_nxt     = cmd_r;
    cur_nxt     = cur_r;
    wb_nxt      = wb_r;
    fill_nxt    = fill_r;
    n_nxt       = n_r;
    na_nxt      = na_r;
    nn_nxt      = nn_r;
    off_nxt     = off_r;
    len_nxt     = len_r;
    word_nxt    = word_r;
    rd_base_nxt = rd_base_r;
    rd_cnt_nxt  = rd_cnt_r;
    rd_oob_nxt  = rd_oob_r;
    hit_nxt     = hit_r;
    rc_nxt      = rc_r;
    mv_src_nxt  = mv_src_r;
    mv_dst_nxt  = mv_dst_r;
    mv_lim_nxt  = mv_lim_r;
    mv_copy_nxt = mv_copy_r;
    pw_nxt      = pw_r;
    pw_addr_nxt = pw_addr_r;
    wr_base_nxt = wr_base_r;
    idx_nxt     = idx_r;
    idx_end_nxt = idx_end_r;
    f0_nxt      = f0_r;
    out_valid_nxt = out_valid_r;
    res_nxt     = res_r;

    fin            = 1'b0;
    fin_commit_upd = 1'b0;
    fin_commit_del = 1'b0;
    fin_code       = RC_OK;
    fin_len        = 2'd0;
    fin_w0         = 32'd0;
    fin_w1         = 32'd0;
    rd_go          = 1'b0;
    rd_at          = '0;
    rd_ret         = S_IDLE;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = 8'd0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          n_nxt   = fill_r;
          off_nxt = '0;
          unique case (q_cmd.kind)
            K_LOOKUP: begin
              wb_nxt = cur_r;
              if (fill_r >= FILL_W'(1) && fill_r <= FILL_W'(HDR_BYTES)) begin
                fin      = 1'b1;
                fin_code = RC_BAD_SIG;
              end else begin
                state_nxt = S_WALK;
              end
            end
            K_DELETE: begin
              wb_nxt = cur_r;
              if (fill_r == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_WALK;
              end
            end
            K_UPDATE: begin
              // copy the live bank into the scratch bank first
              wb_nxt      = ~cur_r;
              mv_src_nxt  = '0;
              mv_dst_nxt  = '0;
              mv_lim_nxt  = fill_r;
              mv_copy_nxt = 1'b1;
              pw_nxt      = 1'b0;
              state_nxt   = S_MOVE;
            end
            default: begin
              fin      = 1'b1;
              fin_code = RC_BAD_PARAM;
            end
          endcase
        end
      end

      // four byte reads, little-endian, from the registered RAM read port
      S_RD: begin
        if (rd_cnt_r < 3'd4) begin
          ram_raddr  = rd_addr[ADDR_W-1:0];
          rd_oob_nxt = (rd_addr >= OFF_W'(BUF_BYTES));
        end
        if (rd_cnt_r != 3'd0) begin
          word_nxt = {(rd_oob_r ? 8'd0 : rbyte), word_r[31:8]};
        end
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == 3'd4) begin
          state_nxt = ret_r;
        end
      end

      // forward byte move: store copy or compaction
      S_MOVE: begin
        if (mv_src_r < mv_lim_r) begin
          ram_raddr   = mv_src_r[ADDR_W-1:0];
          mv_src_nxt  = mv_src_r + FILL_W'(1);
          mv_dst_nxt  = mv_dst_r + FILL_W'(1);
          pw_nxt      = 1'b1;
          pw_addr_nxt = mv_dst_r[ADDR_W-1:0];
        end else begin
          pw_nxt = 1'b0;
        end
        if (pw_r) begin
          ram_we    = 1'b1;
          ram_waddr = pw_addr_r;
          ram_wdata = rbyte;
        end
        if (!(mv_src_r < mv_lim_r) && !pw_r) begin
          if (mv_copy_r) begin
            mv_copy_nxt = 1'b0;
            if (fill_r < FILL_W'(4)) begin
              n_nxt     = '0;
              off_nxt   = '0;
              state_nxt = S_WALK;
            end else begin
              rd_go  = 1'b1;
              rd_at  = '0;
              rd_ret = S_UCHK;
            end
          end else begin
            n_nxt = nn_r;
            if (cmd_r.kind == K_DELETE) begin
              fin            = 1'b1;
              fin_commit_del = 1'b1;
            end else begin
              state_nxt = S_PLACE;
            end
          end
        end
      end

      // a leading zero word counts as an empty store for update
      S_UCHK: begin
        if (word_r == 32'd0) begin
          n_nxt = '0;
        end
        off_nxt   = '0;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (off_r == n_ext || off_r + OFF_W'(4) >= n_ext) begin
          rc_nxt    = RC_NOT_FOUND;
          state_nxt = S_WFAIL;
        end else begin
          rd_go  = 1'b1;
          rd_at  = off_r;
          rd_ret = S_WSIG;
        end
      end

      S_WSIG: begin
        priority if (word_r == 32'd0) begin
          rc_nxt    = RC_NOT_FOUND;
          state_nxt = S_WFAIL;
        end else if (off_r + OFF_W'(HDR_BYTES + 1) > n_ext) begin
          rc_nxt    = RC_TRUNC;
          state_nxt = S_WFAIL;
        end else if (word_r != REC_SIG) begin
          rc_nxt    = RC_BAD_SIG;
          state_nxt = S_WFAIL;
        end else begin
          rd_go  = 1'b1;
          rd_at  = off_r + OFF_W'(8);
          rd_ret = S_WKLO;
        end
      end

      S_WKLO: begin
        hit_nxt = (word_r == cmd_r.key[31:0]);
        rd_go   = 1'b1;
        rd_at   = off_r + OFF_W'(12);
        rd_ret  = S_WKHI;
      end

      S_WKHI: begin
        hit_nxt = hit_r && (word_r == cmd_r.key[63:32]);
        rd_go   = 1'b1;
        rd_at   = off_r + OFF_W'(4);
        rd_ret  = S_WLEN;
      end

      S_WLEN: begin
        len_nxt = word_r;
        if (hit_r) begin
          state_nxt = S_FOUND;
        end else begin
          off_nxt   = (walk_next > 33'(n_r)) ? SAT_OFF : walk_next[OFF_W-1:0];
          state_nxt = S_WALK;
        end
      end

      S_WFAIL: begin
        unique case (cmd_r.kind)
          K_LOOKUP: begin
            fin      = 1'b1;
            fin_code = rc_r;
            fin_len  = (rc_r == RC_NOT_FOUND) ? cmd_r.sw : 2'd0;
          end
          K_UPDATE: begin
            state_nxt = S_PLACE;
          end
          default: begin
            fin      = 1'b1;
            fin_code = rc_r;
          end
        endcase
      end

      S_FOUND: begin
        unique case (cmd_r.kind)
          K_LOOKUP: begin
            priority if (len_r != len_want) begin
              fin      = 1'b1;
              fin_code = RC_NOT_FOUND;
              fin_len  = cmd_r.sw;
            end else if (cmd_r.sw == 2'd0) begin
              fin = 1'b1;
            end else begin
              rd_go  = 1'b1;
              rd_at  = off_r + OFF_W'(HDR_BYTES);
              rd_ret = S_LF0;
            end
          end
          K_UPDATE: begin
            if (len_r != len_want) begin
              state_nxt = S_RM;
            end else begin
              // same length: rewrite the data words in place
              wr_base_nxt = off_r[FILL_W-1:0];
              idx_nxt     = 5'(HDR_BYTES);
              idx_end_nxt = 5'(HDR_BYTES) + 5'({cmd_r.sw, 2'b00});
              nn_nxt      = n_r;
              state_nxt   = S_WRITE;
            end
          end
          default: begin
            state_nxt = S_RM;
          end
        endcase
      end

      S_LF0: begin
        f0_nxt = word_r;
        if (cmd_r.sw == 2'd2) begin
          rd_go  = 1'b1;
          rd_at  = off_r + OFF_W'(HDR_BYTES + 4);
          rd_ret = S_LF1;
        end else begin
          fin     = 1'b1;
          fin_len = cmd_r.sw;
          fin_w0  = word_r;
        end
      end

      S_LF1: begin
        fin     = 1'b1;
        fin_len = cmd_r.sw;
        fin_w0  = f0_r;
        fin_w1  = word_r;
      end

      // remove the record at off_r of length len_r
      S_RM: begin
        if (rm_end > 33'(n_r)) begin
          fin      = 1'b1;
          fin_code = RC_TRUNC;
        end else begin
          nn_nxt      = n_r - (rm_end[FILL_W-1:0] - off_r[FILL_W-1:0]);
          mv_src_nxt  = rm_end[FILL_W-1:0];
          mv_dst_nxt  = off_r[FILL_W-1:0];
          mv_lim_nxt  = n_r;
          mv_copy_nxt = 1'b0;
          pw_nxt      = 1'b0;
          state_nxt   = S_MOVE;
        end
      end

      // append: drop a trailing end word, then check the fit
      S_PLACE: begin
        if (n_r >= FILL_W'(4)) begin
          rd_go  = 1'b1;
          rd_at  = OFF_W'(n_r) - OFF_W'(4);
          rd_ret = S_PDROP;
        end else begin
          na_nxt    = n_r;
          state_nxt = S_PFIT;
        end
      end

      S_PDROP: begin
        na_nxt    = (word_r == 32'd0) ? (n_r - FILL_W'(4)) : n_r;
        state_nxt = S_PFIT;
      end

      S_PFIT: begin
        if (need > (FILL_W+1)'(BUF_BYTES)) begin
          rd_go  = 1'b1;
          rd_at  = '0;
          rd_ret = S_PEV;
        end else begin
          wr_base_nxt = na_r;
          idx_nxt     = 5'd0;
          idx_end_nxt = 5'(HDR_BYTES + 4) + 5'({cmd_r.sw, 2'b00});
          nn_nxt      = need[FILL_W-1:0];
          state_nxt   = S_WRITE;
        end
      end

      // evict the first record if it carries a signature
      S_PEV: begin
        if (word_r != REC_SIG) begin
          fin      = 1'b1;
          fin_code = RC_SMALL;
        end else begin
          rd_go  = 1'b1;
          rd_at  = OFF_W'(4);
          rd_ret = S_PEVL;
        end
      end

      S_PEVL: begin
        len_nxt   = word_r;
        off_nxt   = '0;
        state_nxt = S_RM;
      end

      // byte writes of the record image; bytes past the store are dropped
      S_WRITE: begin
        if (wr_addr < OFF_W'(BUF_BYTES)) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr[ADDR_W-1:0];
          ram_wdata = rec_byte(idx_r, cmd_r.sw, cmd_r.key, cmd_r.w0, cmd_r.w1);
        end
        idx_nxt = idx_r + 5'd1;
        if (idx_r + 5'd1 == idx_end_r) begin
          fin            = 1'b1;
          fin_commit_upd = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // word read request
    if (rd_go) begin
      rd_base_nxt = rd_at;
      rd_cnt_nxt  = 3'd0;
      ret_nxt     = rd_ret;
      state_nxt   = S_RD;
    end

    // result register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin) begin
      out_valid_nxt = 1'b1;
      res_nxt.code  = fin_code;
      res_nxt.len   = fin_len;
      res_nxt.w0    = fin_w0;
      res_nxt.w1    = fin_w1;
      state_nxt     = S_IDLE;
    end
    if (fin_commit_upd) begin
      cur_nxt  = wb_r;
      fill_nxt = nn_r;
    end
    if (fin_commit_del) begin
      fill_nxt = nn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= 1'b0;
      wb_r        <= 1'b0;
      fill_r      <= '0;
      mv_copy_r   <= 1'b0;
      pw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      wb_r        <= wb_nxt;
      fill_r      <= fill_nxt;
      mv_copy_r   <= mv_copy_nxt;
      pw_r        <= pw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    cmd_r     <= cmd_nxt;
    n_r       <= n_nxt;
    na_r      <= na_nxt;
    nn_r      <= nn_nxt;
    off_r     <= off_nxt;
    len_r     <= len_nxt;
    word_r    <= word_nxt;
    rd_base_r <= rd_base_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rd_oob_r  <= rd_oob_nxt;
    hit_r     <= hit_nxt;
    rc_r      <= rc_nxt;
    mv_src_r  <= mv_src_nxt;
    mv_dst_r  <= mv_dst_nxt;
    mv_lim_r  <= mv_lim_nxt;
    pw_addr_r <= pw_addr_nxt;
    wr_base_r <= wr_base_nxt;
    idx_r     <= idx_nxt;
    idx_end_r <= idx_end_nxt;
    f0_r      <= f0_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign stat.fill = fill_r;
  assign stat.busy = (state_r != S_IDLE);

endmodule

### design/tagged_status_record_store_top.sv
// Top level of the tagged status record store: stream ports, front end, engine.
// Depends on tsrs_pkg, tsrs_front, tsrs_engine (and tsrs_ram through it).

// A 256-byte byte store of variable-length records (signature, length, 64-bit
// key, status words) served one operation at a time: lookup, update or delete,
// one result per input transfer. A two-entry queue takes input transfers while
// the engine works. Cost is set by the single byte-wide read port of each RAM
// bank: every 32-bit word is read as four single-byte reads, so a lookup pays
// for one header walk per record passed plus the reads of the data words. An
// update first copies fill_level bytes into the scratch bank (one byte per
// cycle), then walks, compacts one byte per cycle for each removed or evicted
// record, and writes the new record byte by byte; a full store with many
// evictions is the worst case. A failed update leaves the live bank and fill
// level untouched. The store starts empty after reset; no clearing pass is
// needed.
module tagged_status_record_store_top import tsrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // operation[1:0], key[65:2], status_words[67:66], status_word0[99:68],
  // status_word1[131:100], zero fill [135:132]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // result_code[2:0], result_length[4:3], found_word0[36:5],
  // found_word1[68:37], zero fill [71:69]
  output logic [OUT_W-1:0] out_tdata
);

  logic  q_valid, q_pop;
  cmd_t  q_cmd;
  res_t  res;
  stat_t stat;

  tsrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  tsrs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res),
    .stat      (stat)
  );

  assign out_tdata = {3'd0, res.w1, res.w0, res.len, res.code};

  // one item in flight: a taken result is not followed at once by another
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result shown in the cycle after a transfer");

  // a pending result means the engine is parked
  a_idle_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !stat.busy)
    else $error("engine busy while a result waits");

  a_len_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.len != 2'd0 |-> (res.code == RC_OK || res.code == RC_NOT_FOUND))
    else $error("nonzero result length with a failing code");

  a_words_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.w0 != 32'd0 || res.w1 != 32'd0) |-> res.code == RC_OK)
    else $error("found words returned without ok");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FILL_W'(BUF_BYTES))
    else $error("fill level past the store size");

endmodule

### sim/tsrs_checker.sv
// Checker for the tagged status record store: watches both stream channels,
// keeps its own byte image of the store and compares every result transfer.
// Depends on tsrs_pkg.
module tsrs_checker import tsrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending_count
);

  // laid out as on out_tdata: code in the lowest bits
  typedef struct packed {
    logic [31:0] w1;
    logic [31:0] w0;
    logic [1:0]  len;
    logic [2:0]  code;
  } outcome_t;

  logic [7:0] store_img [BUF_BYTES];
  logic [7:0] work_img [BUF_BYTES];
  int unsigned store_len;
  outcome_t outcome_q[$];

  function automatic logic [31:0] rd_word(ref logic [7:0] b [BUF_BYTES], input longint at);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 4; k++)
      if (at + k < BUF_BYTES) v[8*k +: 8] = b[at + k];
    return v;
  endfunction

  function automatic void wr_word(ref logic [7:0] b [BUF_BYTES], input longint at,
                                  input logic [31:0] v);
    for (int k = 0; k < 4; k++)
      if (at + k < BUF_BYTES) b[at + k] = v[8*k +: 8];
  endfunction

  // walk record headers until the key matches
  function automatic rc_t walk_for_key(ref logic [7:0] b [BUF_BYTES], input longint n,
                                       input logic [63:0] key, output longint at);
    longint off;
    off = 0;
    at = 0;
    while (off != n) begin
      if (off + 4 >= n || rd_word(b, off) == 0) return RC_NOT_FOUND;
      if (off + HDR_BYTES + 1 > n) return RC_TRUNC;
      if (rd_word(b, off) != REC_SIG) return RC_BAD_SIG;
      if (rd_word(b, off + 8) == key[31:0] && rd_word(b, off + 12) == key[63:32]) begin
        at = off;
        return RC_OK;
      end
      off += HDR_BYTES + rd_word(b, off + 4);
    end
    return RC_NOT_FOUND;
  endfunction

  function automatic rc_t cut_record(ref logic [7:0] b [BUF_BYTES], input longint off,
                                     input longint n, output longint nn);
    longint stop;
    stop = off + HDR_BYTES + rd_word(b, off + 4);
    nn = n;
    if (stop > n || n > BUF_BYTES) return RC_TRUNC;
    nn = n - (stop - off);
    for (longint i = 0; i < n - stop; i++) b[off + i] = b[stop + i];
    return RC_OK;
  endfunction

  function automatic rc_t add_record(ref logic [7:0] b [BUF_BYTES], input longint n_in,
                                     input logic [63:0] key, input logic [1:0] sw,
                                     input logic [31:0] w0, input logic [31:0] w1,
                                     output longint nn);
    longint n, len;
    n = n_in;
    len = 4 * sw;
    nn = 0;
    if (n >= 4 && rd_word(b, n - 4) == 0) n -= 4;
    if (n + HDR_BYTES + len + 4 > BUF_BYTES) return RC_SMALL;
    wr_word(b, n, REC_SIG);
    wr_word(b, n + 4, 32'(len));
    wr_word(b, n + 8, key[31:0]);
    wr_word(b, n + 12, key[63:32]);
    if (sw >= 1) wr_word(b, n + HDR_BYTES, w0);
    if (sw >= 2) wr_word(b, n + HDR_BYTES + 4, w1);
    n += HDR_BYTES + len;
    wr_word(b, n, 32'd0);
    nn = n + 4;
    return RC_OK;
  endfunction

  // append, evicting the oldest records until the new one fits
  function automatic rc_t fit_record(ref logic [7:0] b [BUF_BYTES], input longint n_in,
                                     input logic [63:0] key, input logic [1:0] sw,
                                     input logic [31:0] w0, input logic [31:0] w1,
                                     output longint nn);
    rc_t rc;
    longint n;
    n = n_in;
    forever begin
      rc = add_record(b, n, key, sw, w0, w1, nn);
      if (rc != RC_SMALL) return rc;
      if (rd_word(b, 0) != REC_SIG) return rc;
      rc = cut_record(b, 0, n, n);
      if (rc != RC_OK) return rc;
    end
  endfunction

  function automatic outcome_t apply_op(input logic [IN_W-1:0] d);
    logic [1:0]  op, sw;
    logic [63:0] key;
    logic [31:0] w0, w1;
    rc_t rc;
    longint at, n, nn;
    outcome_t r;
    op  = d[1:0];
    key = d[65:2];
    sw  = d[67:66];
    w0  = d[99:68];
    w1  = d[131:100];
    r = '0;
    nn = 0;
    at = 0;
    case (op)
      OP_LOOKUP: begin
        n = store_len;
        if (sw > MAX_STATUS_WORDS) rc = RC_BAD_PARAM;
        else if (n >= 1 && n <= HDR_BYTES) rc = RC_BAD_SIG;
        else begin
          rc = walk_for_key(store_img, n, key, at);
          if (rc == RC_OK) begin
            if (rd_word(store_img, at + 4) != 4 * sw) rc = RC_NOT_FOUND;
            else begin
              if (sw >= 1) r.w0 = rd_word(store_img, at + HDR_BYTES);
              if (sw >= 2) r.w1 = rd_word(store_img, at + HDR_BYTES + 4);
            end
          end
          if (rc == RC_OK || rc == RC_NOT_FOUND) r.len = sw;
        end
      end
      OP_UPDATE: begin
        if (sw == 0 || sw > MAX_STATUS_WORDS) rc = RC_BAD_PARAM;
        else begin
          work_img = store_img;
          n = store_len;
          if (n < 4) n = 0;
          if (n != 0 && rd_word(work_img, 0) == 0) n = 0;
          rc = walk_for_key(work_img, n, key, at);
          if (rc == RC_OK) begin
            if (rd_word(work_img, at + 4) != 4 * sw) begin
              rc = cut_record(work_img, at, n, n);
              if (rc == RC_OK) rc = fit_record(work_img, n, key, sw, w0, w1, nn);
            end else begin
              wr_word(work_img, at + HDR_BYTES, w0);
              if (sw >= 2) wr_word(work_img, at + HDR_BYTES + 4, w1);
              nn = n;
            end
          end else rc = fit_record(work_img, n, key, sw, w0, w1, nn);
          if (rc == RC_OK) begin
            store_img = work_img;
            store_len = nn;
          end
        end
      end
      OP_DELETE: begin
        n = store_len;
        if (n == 0) rc = RC_OK;
        else begin
          rc = walk_for_key(store_img, n, key, at);
          if (rc == RC_OK) begin
            rc = cut_record(store_img, at, n, nn);
            if (rc == RC_OK) store_len = nn;
          end
        end
      end
      default: rc = RC_BAD_PARAM;
    endcase
    r.code = rc;
    r.len = r.len;
    return r;
  endfunction

  assign pending_count = outcome_q.size();

  always @(posedge clk) begin
    outcome_t exp_r, got;
    if (!rst_n) begin
      store_len = 0;
      for (int i = 0; i < BUF_BYTES; i++) store_img[i] = '0;
      fail_count <= 0;
      outcome_q.delete();
    end else begin
      // result first: the expectation of a same-cycle input is never its own
      if (out_tvalid && out_tready) begin
        got = out_tdata[68:0];
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = outcome_q.pop_front();
          if (got !== exp_r) begin
            $display({"%0t: result differs, expected code=%0d len=%0d w0=%h w1=%h,",
                      " actual code=%0d len=%0d w0=%h w1=%h"},
                     $time, exp_r.code, exp_r.len, exp_r.w0, exp_r.w1,
                     got.code, got.len, got.w0, got.w1);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) outcome_q.push_back(apply_op(in_tdata));
    end
  end

endmodule

### sim/tagged_status_record_store_top_test.sv
// Stimulus and verdict for the tagged status record store.
// Depends on tsrs_pkg, tagged_status_record_store_top and tsrs_checker.
module tagged_status_record_store_top_test;
  import tsrs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  int fail_count, pending_count;
  bit calm_tail = 1'b0;
  bit long_hold = 1'b0;
  logic [63:0] key_pool [8];

  always #10 clk = ~clk;

  tagged_status_record_store_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tsrs_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // send one transfer, at times with a random gap ahead of it
  task automatic send_op(input logic [1:0] op, input logic [63:0] key,
                         input logic [1:0] sw, input logic [31:0] w0,
                         input logic [31:0] w1);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, w1, w0, sw, key, op};
    // ready is stable between edges: check it at the falling edge
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off, none in the tail
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    #300_000_000;
    $display("tagged_status_record_store_top: mismatch");
    $finish;
  end

  initial begin
    logic [1:0] op, sw;
    logic [63:0] key;
    int cnt;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty store, bad parameters, extremes, fill and evict
    send_op(OP_LOOKUP, '0, 2'd0, '0, '0);
    send_op(OP_DELETE, '0, 2'd1, '0, '0);
    send_op(2'd3, '1, 2'd3, '1, '1);
    send_op(OP_LOOKUP, '1, 2'd3, '0, '0);
    send_op(OP_UPDATE, '1, 2'd0, '1, '1);
    send_op(OP_UPDATE, '1, 2'd3, '1, '1);
    send_op(OP_UPDATE, '0, 2'd1, '1, '0);
    send_op(OP_UPDATE, '1, 2'd2, '1, '1);
    send_op(OP_LOOKUP, '1, 2'd2, '0, '0);
    send_op(OP_LOOKUP, '1, 2'd1, '0, '0);
    send_op(OP_LOOKUP, '0, 2'd1, '0, '0);
    send_op(OP_LOOKUP, '0, 2'd0, '0, '0);
    send_op(OP_UPDATE, '0, 2'd1, 32'h5555_aaaa, '0);
    send_op(OP_UPDATE, '1, 2'd1, 32'h1234_5678, '1);
    send_op(OP_LOOKUP, '1, 2'd1, '0, '0);
    send_op(OP_LOOKUP, 64'h1234, 2'd1, '0, '0);
    for (int i = 0; i < 8; i++)
      send_op(OP_UPDATE, {$urandom, $urandom}, 2'd2, $urandom, $urandom);
    send_op(OP_DELETE, '0, 2'd0, '0, '0);
    send_op(OP_DELETE, 64'h77, 2'd0, '0, '0);

    // random: mostly keys from a small pool so hits, resizes and deletes occur
    for (int i = 0; i < 725; i++) begin
      if (i == 100) long_hold = 1'b1;
      if (i == 650) calm_tail = 1'b1;
      cnt = $urandom_range(0, 99);
      op = (cnt < 40) ? OP_LOOKUP : (cnt < 80) ? OP_UPDATE : (cnt < 96) ? OP_DELETE : 2'd3;
      key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
            key_pool[$urandom_range(0, 7)];
      sw = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) :
           2'($urandom_range(1, 2));
      send_op(op, key, sw, $urandom, $urandom);
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("tagged_status_record_store_top: match");
    end else begin
      $display("tagged_status_record_store_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/tsrs_pkg.sv
design/tsrs_ram.sv
design/tsrs_front.sv
design/tsrs_engine.sv
design/tagged_status_record_store_top.sv
sim/tsrs_checker.sv
sim/tagged_status_record_store_top_test.sv
